// File: design/smos_pkg.sv
package smos_pkg;

  // killer store depth in plies
  localparam int PLY_LIMIT = 64;
  localparam int PLY_W     = 6;
  localparam int KIL_AW    = (PLY_LIMIT > 1) ? $clog2(PLY_LIMIT) : 1;

  localparam int MOVE_W  = 16;
  localparam int SCORE_W = 15;
  localparam int HIST_W  = 13;
  localparam int HIST_AW = 13;
  localparam int DEPTH_W = 6;
  localparam int PIECE_W = 3;

  // operation codes
  localparam logic [1:0] OP_SCORE  = 2'd0;
  localparam logic [1:0] OP_CUTOFF = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [SCORE_W-1:0] SCORE_SUGGESTED = 15'd30000;
  localparam logic [SCORE_W-1:0] CAPTURE_BASE    = 15'd10000;
  localparam logic [SCORE_W-1:0] SCORE_KILLER_A  = 15'd9000;
  localparam logic [SCORE_W-1:0] SCORE_KILLER_B  = 15'd8000;
  localparam logic [HIST_W-1:0]  HIST_CEIL       = 13'd7000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic clr_step;
  } cmd_t;

  typedef struct packed {
    logic op_clear;
    logic clr_last;
  } sts_t;

  // material value by piece type
  function automatic logic [3:0] piece_value(input logic [PIECE_W-1:0] kind);
    logic [3:0] v;
    unique case (kind)
      3'd1:    v = 4'd1;
      3'd2:    v = 4'd3;
      3'd3:    v = 4'd3;
      3'd4:    v = 4'd5;
      3'd5:    v = 4'd9;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/search_move_ordering_scorer.sv
// move ordering scorer with killer and history stores. a transaction is
// accepted on a rising edge with start high and busy low, and its single
// result is registered on order_score by the evaluate step, marked by done
// for exactly one cycle; the receiver cannot stall, so results must be taken
// as they come. score and cutoff transactions first read the history and
// killer memories (registered reads) and then evaluate and write back; busy
// stays high until one transaction is through, so the next one can only be
// accepted after that. after reset and after each clear transaction the block runs
// a clearing pass over the 8192-entry history memory, one entry per cycle,
// holding busy high throughout; killers are cleared at once through
// per-ply valid bits
module search_move_ordering_scorer import smos_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [MOVE_W-1:0]  move_code,
  input  logic               is_capture,
  input  logic               is_en_passant,
  input  logic [PIECE_W-1:0] victim_type,
  input  logic [PIECE_W-1:0] attacker_type,
  input  logic [PLY_W-1:0]   ply_index,
  input  logic               side_to_move,
  input  logic [DEPTH_W-1:0] remaining_depth,
  input  logic [MOVE_W-1:0]  suggested_move,
  output logic               done,
  output logic [SCORE_W-1:0] order_score
);

  // command and status between controller and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: idle, evaluate, clearing pass
  smos_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // stores, scoring and update logic
  smos_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .operation       (operation),
    .move_code       (move_code),
    .is_capture      (is_capture),
    .is_en_passant   (is_en_passant),
    .victim_type     (victim_type),
    .attacker_type   (attacker_type),
    .ply_index       (ply_index),
    .side_to_move    (side_to_move),
    .remaining_depth (remaining_depth),
    .suggested_move  (suggested_move),
    .done            (done),
    .order_score     (order_score)
  );

`ifndef SYNTH
  // an accepted transaction keeps the block busy for its evaluate cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low right after accept");

  // the result strobe follows acceptance after the evaluate state
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("missing result two cycles after accept");

  // a result only comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without work");

  // scores stay in the legal range
  a_score_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (order_score <= SCORE_SUGGESTED))
    else $error("score out of range");
`endif

endmodule

// File: design/smos_ctrl.sv
module smos_ctrl import smos_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = sts.op_clear ? ST_CLEAR : ST_IDLE;
      end
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    busy         = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

// File: design/smos_datapath.sv
module smos_datapath import smos_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [1:0]         operation,
  input  logic [MOVE_W-1:0]  move_code,
  input  logic               is_capture,
  input  logic               is_en_passant,
  input  logic [PIECE_W-1:0] victim_type,
  input  logic [PIECE_W-1:0] attacker_type,
  input  logic [PLY_W-1:0]   ply_index,
  input  logic               side_to_move,
  input  logic [DEPTH_W-1:0] remaining_depth,
  input  logic [MOVE_W-1:0]  suggested_move,
  output logic               done,
  output logic [SCORE_W-1:0] order_score
);

  logic [HIST_W-1:0]     hist_mem [2**HIST_AW];
  logic [2*MOVE_W-1:0]   kil_mem  [PLY_LIMIT];
  logic [PLY_LIMIT-1:0]  kil_valid;

  logic [1:0]            op_q;
  logic [MOVE_W-1:0]     mv_q;
  logic                  cap_q;
  logic                  ep_q;
  logic [PIECE_W-1:0]    vic_q;
  logic [PIECE_W-1:0]    att_q;
  logic                  ply_ok_q;
  logic [KIL_AW-1:0]     kaddr_q;
  logic [HIST_AW-1:0]    hidx_q;
  logic [DEPTH_W-1:0]    depth_q;
  logic [MOVE_W-1:0]     sugg_q;

  logic [HIST_W-1:0]     hist_rd;
  logic [2*MOVE_W-1:0]   kil_rd;
  logic                  kil_vld_rd;

  logic [HIST_AW-1:0]    clr_cnt;

  logic [KIL_AW-1:0]     kaddr_in;
  logic [HIST_AW-1:0]    hidx_in;
  logic                  ply_ok_in;

  logic [MOVE_W-1:0]     k0;
  logic [MOVE_W-1:0]     k1;
  logic [3:0]            vic_val;
  logic [SCORE_W-1:0]    cap_score;
  logic [SCORE_W-1:0]    score;
  logic [2*DEPTH_W-1:0]  depth_sq;
  logic [HIST_W:0]       hist_sum;
  logic [HIST_W-1:0]     hist_new;
  logic                  kil_we;
  logic                  hist_we;
  logic                  is_cutoff;

  assign kaddr_in  = KIL_AW'(ply_index);
  assign hidx_in   = {side_to_move, move_code[5:0], move_code[11:6]};
  assign ply_ok_in = int'(ply_index) < PLY_LIMIT;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q     <= operation;
      mv_q     <= move_code;
      cap_q    <= is_capture | is_en_passant;
      ep_q     <= is_en_passant;
      vic_q    <= victim_type;
      att_q    <= attacker_type;
      ply_ok_q <= ply_ok_in;
      kaddr_q  <= kaddr_in;
      hidx_q   <= hidx_in;
      depth_q  <= remaining_depth;
      sugg_q   <= suggested_move;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hist_rd    <= hist_mem[hidx_in];
      kil_rd     <= kil_mem[kaddr_in];
      kil_vld_rd <= kil_valid[kaddr_in];
    end
  end

  always_comb begin
    k0        = kil_vld_rd ? kil_rd[MOVE_W-1:0] : '0;
    k1        = kil_vld_rd ? kil_rd[2*MOVE_W-1:MOVE_W] : '0;
    vic_val   = ep_q ? piece_value(3'd1) : piece_value(vic_q);
    cap_score = CAPTURE_BASE + {7'd0, vic_val, 4'd0} - {11'd0, piece_value(att_q)};
    priority if (sugg_q != '0 && mv_q == sugg_q) begin
      score = SCORE_SUGGESTED;
    end else if (cap_q) begin
      score = cap_score;
    end else if (ply_ok_q && k0 != '0 && mv_q == k0) begin
      score = SCORE_KILLER_A;
    end else if (ply_ok_q && k1 != '0 && mv_q == k1) begin
      score = SCORE_KILLER_B;
    end else begin
      score = {2'd0, hist_rd};
    end
  end

  assign is_cutoff = cmd.exec && op_q == OP_CUTOFF && !cap_q;
  assign kil_we    = is_cutoff && ply_ok_q && k0 != mv_q;
  assign hist_we   = is_cutoff;
  assign depth_sq  = {6'd0, depth_q} * {6'd0, depth_q};
  assign hist_sum  = {1'b0, hist_rd} + {2'd0, depth_sq};
  assign hist_new  = (hist_sum > {1'b0, HIST_CEIL}) ? HIST_CEIL : hist_sum[HIST_W-1:0];

  // newest killer in the low half, older one shifted up
  always_ff @(posedge clk) begin
    if (kil_we) begin
      kil_mem[kaddr_q] <= {k0, mv_q};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kil_valid <= '0;
    end else if (cmd.exec && op_q == OP_CLEAR) begin
      kil_valid <= '0;
    end else if (kil_we) begin
      kil_valid[kaddr_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      hist_mem[clr_cnt] <= '0;
    end else if (hist_we) begin
      hist_mem[hidx_q] <= hist_new;
    end
  end

  // wraps back to zero at the end of each sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign sts.op_clear = op_q == OP_CLEAR;
  assign sts.clr_last = &clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      order_score <= (op_q == OP_SCORE) ? score : '0;
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top import smos_pkg::*; ();

  // operation code the block leaves unused: no store change, score 0
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1630;
  localparam int MOVE_POOL    = 10;
  // reset pass plus every clear walks 8192 history entries; the limit covers
  // some thirty clears and ~1650 items with ample margin
  localparam int CYCLE_LIMIT  = 2000000;
  // result is registered after the evaluate state, leave some margin
  localparam int DRAIN_CYCLES = 8;
  localparam int PRINT_CAP    = 50;

  // one transaction as seen on the input ports
  typedef struct {
    logic [1:0]         op;
    logic [MOVE_W-1:0]  mv;
    logic               cap;
    logic               ep;
    logic [PIECE_W-1:0] victim;
    logic [PIECE_W-1:0] attacker;
    logic [PLY_W-1:0]   ply;
    logic               side;
    logic [DEPTH_W-1:0] depth;
    logic [MOVE_W-1:0]  sugg;
  } move_item_t;

  // keeps its own killer and history stores and the queue of scores
  // that the block still owes
  class order_scoreboard;
    logic [MOVE_W-1:0]  killer_mem [2*PLY_LIMIT];
    logic [HIST_W-1:0]  history_mem [1 << HIST_AW];
    logic [SCORE_W-1:0] expected_scores [$];
    int mismatches;
    int matched;

    function new();
      mismatches = 0;
      matched = 0;
      wipe_stores();
    endfunction

    function void wipe_stores();
      foreach (killer_mem[i]) killer_mem[i] = '0;
      foreach (history_mem[i]) history_mem[i] = '0;
    endfunction

    // material value; type 7 counts like none and king
    function int material(logic [PIECE_W-1:0] kind);
      int v;
      case (kind)
        3'd1:       v = 1;
        3'd2, 3'd3: v = 3;
        3'd4:       v = 5;
        3'd5:       v = 9;
        default:    v = 0;
      endcase
      return v;
    endfunction

    function void note_item(move_item_t it);
      logic capture;
      logic ply_ok;
      int   kb;
      int   hidx;
      int   score;
      int   sum;
      capture = it.cap | it.ep;
      ply_ok  = int'(it.ply) < PLY_LIMIT;
      kb      = ply_ok ? int'(it.ply) * 2 : 0;
      // history index: side, from square, to square
      hidx    = int'({it.side, it.mv[5:0], it.mv[11:6]});
      score   = 0;
      case (it.op)
        OP_SCORE: begin
          if (it.sugg != '0 && it.mv == it.sugg) begin
            score = int'(SCORE_SUGGESTED);
          end else if (capture) begin
            // en passant always takes a pawn
            score = int'(CAPTURE_BASE) + 16 * material(it.ep ? 3'd1 : it.victim)
                    - material(it.attacker);
          end else if (ply_ok && killer_mem[kb] != '0 && it.mv == killer_mem[kb]) begin
            score = int'(SCORE_KILLER_A);
          end else if (ply_ok && killer_mem[kb+1] != '0 && it.mv == killer_mem[kb+1]) begin
            score = int'(SCORE_KILLER_B);
          end else begin
            score = int'(history_mem[hidx]);
          end
        end
        OP_CUTOFF: begin
          if (!capture) begin
            if (ply_ok && killer_mem[kb] != it.mv) begin
              killer_mem[kb+1] = killer_mem[kb];
              killer_mem[kb]   = it.mv;
            end
            sum = int'(history_mem[hidx]) + int'(it.depth) * int'(it.depth);
            history_mem[hidx] = (sum > int'(HIST_CEIL)) ? HIST_CEIL : HIST_W'(sum);
          end
        end
        OP_CLEAR: wipe_stores();
        default: ;
      endcase
      expected_scores.push_back(SCORE_W'(score));
    endfunction

    task report(string msg);
      if (mismatches < PRINT_CAP) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_result(logic [SCORE_W-1:0] got);
      logic [SCORE_W-1:0] want;
      if (expected_scores.size() == 0) begin
        report($sformatf("order_score %0d with no transaction pending", got));
      end else begin
        want = expected_scores.pop_front();
        if (got !== want) begin
          report($sformatf("order_score got %0d expected %0d", got, want));
        end else begin
          matched++;
        end
      end
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         operation;
  logic [MOVE_W-1:0]  move_code;
  logic               is_capture;
  logic               is_en_passant;
  logic [PIECE_W-1:0] victim_type;
  logic [PIECE_W-1:0] attacker_type;
  logic [PLY_W-1:0]   ply_index;
  logic               side_to_move;
  logic [DEPTH_W-1:0] remaining_depth;
  logic [MOVE_W-1:0]  suggested_move;
  logic               done;
  logic [SCORE_W-1:0] order_score;

  order_scoreboard    sb;
  int                 cycle_count;
  bit                 back_to_back;
  logic [MOVE_W-1:0]  move_pool [MOVE_POOL];
  int                 n_score, n_cutoff, n_clear, n_unused;

  search_move_ordering_scorer dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .operation       (operation),
    .move_code       (move_code),
    .is_capture      (is_capture),
    .is_en_passant   (is_en_passant),
    .victim_type     (victim_type),
    .attacker_type   (attacker_type),
    .ply_index       (ply_index),
    .side_to_move    (side_to_move),
    .remaining_depth (remaining_depth),
    .suggested_move  (suggested_move),
    .done            (done),
    .order_score     (order_score)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake or a missing result ends here
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, sb.expected_scores.size());
    $display("FAIL");
    $finish;
  end

  // monitor: all values read here are the ones before the edge, since the
  // driver and the block only change signals through nonblocking updates
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(order_score);
    if (!rst && start === 1'b1 && busy === 1'b0) begin
      move_item_t seen;
      seen.op       = operation;
      seen.mv       = move_code;
      seen.cap      = is_capture;
      seen.ep       = is_en_passant;
      seen.victim   = victim_type;
      seen.attacker = attacker_type;
      seen.ply      = ply_index;
      seen.side     = side_to_move;
      seen.depth    = remaining_depth;
      seen.sugg     = suggested_move;
      sb.note_item(seen);
      case (seen.op)
        OP_SCORE:  n_score++;
        OP_CUTOFF: n_cutoff++;
        OP_CLEAR:  n_clear++;
        default:   n_unused++;
      endcase
    end
  end

  function automatic move_item_t make_item(
    logic [1:0] op, logic [MOVE_W-1:0] mv, logic cap, logic ep,
    logic [PIECE_W-1:0] victim, logic [PIECE_W-1:0] attacker,
    logic [PLY_W-1:0] ply, logic side, logic [DEPTH_W-1:0] depth,
    logic [MOVE_W-1:0] sugg);
    move_item_t it;
    it.op = op;  it.mv = mv;  it.cap = cap;  it.ep = ep;
    it.victim = victim;  it.attacker = attacker;  it.ply = ply;
    it.side = side;  it.depth = depth;  it.sugg = sugg;
    return it;
  endfunction

  // small move set so that cutoffs fill killers that later scores hit;
  // one slot holds the empty move, one shares from/to with another
  task refill_move_pool();
    foreach (move_pool[i]) move_pool[i] = MOVE_W'($urandom);
    move_pool[MOVE_POOL-1] = {~move_pool[0][15:12], move_pool[0][11:0]};
    move_pool[MOVE_POOL-2] = '0;
  endtask

  function automatic move_item_t draw_move_item();
    move_item_t it;
    int roll;
    int pick;
    roll = $urandom_range(0, 999);
    if (roll < 60) begin
      // noise: every field across its full width
      return make_item(2'($urandom), MOVE_W'($urandom), 1'($urandom), 1'($urandom),
                       3'($urandom), 3'($urandom), 6'($urandom), 1'($urandom),
                       6'($urandom), MOVE_W'($urandom));
    end
    if (roll < 64)       it.op = OP_CLEAR;
    else if (roll < 84)  it.op = OP_UNUSED;
    else if (roll < 540) it.op = OP_SCORE;
    else                 it.op = OP_CUTOFF;
    it.mv       = move_pool[$urandom_range(0, MOVE_POOL-1)];
    it.ply      = ($urandom_range(0, 7) != 0) ? 6'($urandom_range(0, 3)) : 6'($urandom);
    it.side     = 1'($urandom);
    // mostly small bonuses so saturation takes a while
    it.depth    = ($urandom_range(0, 7) != 0) ? 6'($urandom_range(0, 9)) : 6'($urandom);
    it.victim   = 3'($urandom);
    it.attacker = 3'($urandom);
    it.cap      = ($urandom_range(0, 5) == 0);
    it.ep       = ($urandom_range(0, 15) == 0);
    pick = $urandom_range(0, 9);
    if (pick < 3)      it.sugg = '0;
    else if (pick < 5) it.sugg = it.mv;
    else if (pick < 8) it.sugg = move_pool[$urandom_range(0, MOVE_POOL-1)];
    else               it.sugg = MOVE_W'($urandom);
    return it;
  endfunction

  // called in the time step of a rising edge; returns in the time step of
  // the edge that accepted the transaction, with start still high
  task send_item(move_item_t it);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    operation       <= it.op;
    move_code       <= it.mv;
    is_capture      <= it.cap;
    is_en_passant   <= it.ep;
    victim_type     <= it.victim;
    attacker_type   <= it.attacker;
    ply_index       <= it.ply;
    side_to_move    <= it.side;
    remaining_depth <= it.depth;
    suggested_move  <= it.sugg;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  initial begin
    logic [MOVE_W-1:0] mv_a, mv_b, mv_c, mv_d;
    move_item_t it;
    sb = new();
    back_to_back = 1'b0;
    n_score = 0;  n_cutoff = 0;  n_clear = 0;  n_unused = 0;
    rst             <= 1'b1;
    start           <= 1'b0;
    operation       <= OP_SCORE;
    move_code       <= '0;
    is_capture      <= 1'b0;
    is_en_passant   <= 1'b0;
    victim_type     <= '0;
    attacker_type   <= '0;
    ply_index       <= '0;
    side_to_move    <= 1'b0;
    remaining_depth <= '0;
    suggested_move  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    mv_a = 16'h5A3C;
    mv_b = 16'hA1C7;
    mv_c = 16'h0F42;
    mv_d = 16'hFFFE;
    // empty store, empty killers, no suggested move
    send_item(make_item(OP_SCORE, '0, 0, 0, 0, 0, 0, 0, 0, '0));
    // suggested move wins over a capture, all fields at their top
    send_item(make_item(OP_SCORE, 16'hFFFF, 1, 1, 7, 7, 63, 1, 63, 16'hFFFF));
    // capture scoring: queen by pawn, type 7 on both sides, king by king
    send_item(make_item(OP_SCORE, mv_c, 1, 0, 5, 1, 0, 0, 0, mv_a));
    send_item(make_item(OP_SCORE, mv_c, 1, 0, 7, 7, 0, 0, 0, '0));
    send_item(make_item(OP_SCORE, mv_c, 1, 0, 6, 6, 0, 0, 0, '0));
    // en passant without the capture flag, victim field ignored
    send_item(make_item(OP_SCORE, mv_c, 0, 1, 0, 1, 0, 0, 0, '0));
    // cutoffs: first killer, already-first repeat saturating history, then shift
    send_item(make_item(OP_CUTOFF, mv_a, 0, 0, 0, 0, 0, 0, 63, '0));
    send_item(make_item(OP_CUTOFF, mv_a, 0, 0, 0, 0, 0, 0, 63, '0));
    send_item(make_item(OP_CUTOFF, mv_b, 0, 0, 0, 0, 0, 0, 1, '0));
    send_item(make_item(OP_SCORE, mv_a, 0, 0, 0, 0, 0, 0, 0, '0));
    send_item(make_item(OP_SCORE, mv_b, 0, 0, 0, 0, 0, 0, 0, '0));
    // other ply, other side: history only
    send_item(make_item(OP_SCORE, mv_a, 0, 0, 0, 0, 63, 0, 0, '0));
    send_item(make_item(OP_SCORE, mv_a, 0, 0, 0, 0, 5, 1, 0, '0));
    // cutoff on a capture leaves the stores alone
    send_item(make_item(OP_CUTOFF, mv_c, 1, 0, 3, 2, 1, 0, 40, '0));
    send_item(make_item(OP_SCORE, mv_c, 0, 0, 0, 0, 1, 0, 0, '0));
    // empty move as cutoff: matches the empty slot, so killers stay
    send_item(make_item(OP_CUTOFF, '0, 0, 0, 0, 0, 2, 0, 5, '0));
    send_item(make_item(OP_SCORE, '0, 0, 0, 0, 0, 2, 0, 0, '0));
    // unused operation code with all fields high
    send_item(make_item(OP_UNUSED, 16'hFFFF, 1, 1, 7, 7, 63, 1, 63, 16'hFFFF));
    // highest ply, zero depth
    send_item(make_item(OP_CUTOFF, mv_d, 0, 0, 0, 0, 63, 1, 0, '0));
    send_item(make_item(OP_SCORE, mv_d, 0, 0, 0, 0, 63, 1, 0, mv_a));
    // clear, then old killers and history are gone
    send_item(make_item(OP_CLEAR, mv_a, 0, 0, 0, 0, 0, 0, 0, '0));
    send_item(make_item(OP_SCORE, mv_a, 0, 0, 0, 0, 0, 0, 0, '0));
    send_item(make_item(OP_SCORE, mv_b, 0, 0, 0, 0, 0, 0, 0, mv_a));

    // ---- random part ----
    refill_move_pool();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // alternate between gappy traffic and back-to-back stretches
      if (i % 64 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      it = draw_move_item();
      send_item(it);
      if (it.op == OP_CLEAR) refill_move_pool();
    end
    start <= 1'b0;

    while (sb.expected_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d score, %0d cutoff, %0d clear and %0d unused-code transactions",
             n_score, n_cutoff, n_clear, n_unused);
    $display("%0d results matched, %0d mismatches, %0d cycles",
             sb.matched, sb.mismatches, cycle_count);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
